@@ hw/rtl/pt64_pkg.sv @@
package pt64_pkg;

    localparam int BASE_WIDTH = 6;
    localparam int BASE_COUNT = 12;
    localparam int BASE_IDX_WIDTH = 4;

    typedef logic [BASE_WIDTH-1:0]     t_base;
    typedef logic [BASE_IDX_WIDTH-1:0] t_base_idx;

    localparam t_base WITNESS_TABLE [BASE_COUNT] = '{
        6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13,
        6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
    };

endpackage

@@ hw/rtl/primality_test_64.sv @@
// Deterministic Miller-Rabin primality test for one unsigned candidate.
// The input channel (i_in_valid / o_in_ready) takes one request holding
// i_candidate_value; only its low VALUE_WIDTH bits are tested. The output
// channel (o_out_valid / i_out_ready) returns one request per input with
// o_is_prime set when the candidate is prime.
// The block works on one candidate at a time. Every modular product is made
// by add-and-double, one modular add per cycle. A base costs up to
// 2*(bits of d) + s - 1 products for an odd candidate, at most 126 for a
// 64-bit one; most composites stop after the first base and values below two
// go straight to the finish state. Splitting n-1 shifts out one trailing zero
// per step, and reducing a small base below n subtracts n once per step.
// The result sits in an output register; the block accepts the next
// candidate while it waits, and a second finished result holds in the
// finish state until the receiver takes the first one, so a stalled
// receiver stops the block without losing anything.
// Reset (synchronous, active low) returns the controller to idle and drops
// any pending output request.
module primality_test_64 #(
    parameter int VALUE_WIDTH   = 64,
    parameter int WITNESS_COUNT = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_candidate_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_is_prime
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SPLIT = 4'd1;
    localparam logic [3:0] S_WIT   = 4'd2;
    localparam logic [3:0] S_RED   = 4'd3;
    localparam logic [3:0] S_POW   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_POWA  = 4'd6;
    localparam logic [3:0] S_POWB  = 4'd7;
    localparam logic [3:0] S_CHK   = 4'd8;
    localparam logic [3:0] S_SQ    = 4'd9;
    localparam logic [3:0] S_SQD   = 4'd10;
    localparam logic [3:0] S_NEXT  = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    localparam pt64_pkg::t_base_idx LAST_IDX = pt64_pkg::t_base_idx'(WITNESS_COUNT - 1);
    localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

    logic [3:0]   r_state, n_state;
    logic [3:0]   r_ret, n_ret;
    logic [W-1:0] r_n, n_n;
    logic [W-1:0] r_nm1, n_nm1;
    logic [W-1:0] r_d, n_d;
    logic [CW-1:0] r_s, n_s;
    logic [CW-1:0] r_r, n_r;
    logic [W-1:0] r_e, n_e;
    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_b, n_b;
    logic [W-1:0] r_mx, n_mx;
    logic [W-1:0] r_my, n_my;
    logic [W-1:0] r_mp, n_mp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic         r_sub, n_sub;
    pt64_pkg::t_base_idx r_idx, n_idx;
    logic         r_res, n_res;
    logic         r_ovalid, n_ovalid;
    logic         r_oprime, n_oprime;

    logic [W-1:0] w_cand;
    logic [W-1:0] w_base;
    logic [W-1:0] w_addend;
    logic [W:0]   w_sum;
    logic [W:0]   w_red;
    logic [W-1:0] w_madd;

    assign w_cand   = i_candidate_value[W-1:0];
    assign w_base   = {{(W-pt64_pkg::BASE_WIDTH){1'b0}}, pt64_pkg::WITNESS_TABLE[r_idx]};
    // One modular add per cycle: a double when r_sub is low, else add the multiplicand.
    assign w_addend = r_sub ? r_mx : r_mp;
    assign w_sum    = {1'b0, r_mp} + {1'b0, w_addend};
    assign w_red    = w_sum - {1'b0, r_n};
    assign w_madd   = (w_sum >= {1'b0, r_n}) ? w_red[W-1:0] : w_sum[W-1:0];

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_is_prime  = r_oprime;

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_n      = r_n;
        n_nm1    = r_nm1;
        n_d      = r_d;
        n_s      = r_s;
        n_r      = r_r;
        n_e      = r_e;
        n_acc    = r_acc;
        n_b      = r_b;
        n_mx     = r_mx;
        n_my     = r_my;
        n_mp     = r_mp;
        n_cnt    = r_cnt;
        n_sub    = r_sub;
        n_idx    = r_idx;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        n_oprime = r_oprime;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_n   = w_cand;
                    n_nm1 = w_cand - ONE;
                    n_d   = w_cand - ONE;
                    n_s   = '0;
                    n_idx = '0;
                    if (w_cand < 2) begin
                        n_res   = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SPLIT;
                    end
                end
            end
            S_SPLIT: begin
                if (r_d[0]) begin
                    n_state = S_WIT;
                end else begin
                    n_d = r_d >> 1;
                    n_s = r_s + 1'b1;
                end
            end
            S_WIT: begin
                if (r_n == w_base) begin
                    n_res   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_b     = w_base;
                    n_acc   = ONE;
                    n_e     = r_d;
                    n_state = S_RED;
                end
            end
            S_RED: begin
                if (r_b >= r_n) begin
                    n_b = r_b - r_n;
                end else begin
                    n_state = S_POW;
                end
            end
            S_POW: begin
                if (r_e == '0) begin
                    n_state = S_CHK;
                end else if (r_e[0]) begin
                    n_mx    = r_acc;
                    n_my    = r_b;
                    n_mp    = '0;
                    n_cnt   = CW'(W - 1);
                    n_sub   = 1'b0;
                    n_ret   = S_POWA;
                    n_state = S_MUL;
                end else begin
                    n_mx    = r_b;
                    n_my    = r_b;
                    n_mp    = '0;
                    n_cnt   = CW'(W - 1);
                    n_sub   = 1'b0;
                    n_ret   = S_POWB;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_mp = w_madd;
                if (!r_sub && r_my[W-1]) begin
                    n_sub = 1'b1;
                end else begin
                    n_sub = 1'b0;
                    n_my  = r_my << 1;
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        n_state = r_ret;
                    end
                end
            end
            S_POWA: begin
                n_acc   = r_mp;
                n_mx    = r_b;
                n_my    = r_b;
                n_mp    = '0;
                n_cnt   = CW'(W - 1);
                n_sub   = 1'b0;
                n_ret   = S_POWB;
                n_state = S_MUL;
            end
            S_POWB: begin
                n_b     = r_mp;
                n_e     = r_e >> 1;
                n_state = S_POW;
            end
            S_CHK: begin
                if (r_acc == ONE || r_acc == r_nm1) begin
                    n_state = S_NEXT;
                end else begin
                    n_r     = CW'(1);
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                if (r_r < r_s) begin
                    n_mx    = r_acc;
                    n_my    = r_acc;
                    n_mp    = '0;
                    n_cnt   = CW'(W - 1);
                    n_sub   = 1'b0;
                    n_ret   = S_SQD;
                    n_state = S_MUL;
                end else begin
                    n_res   = 1'b0;
                    n_state = S_FIN;
                end
            end
            S_SQD: begin
                n_acc = r_mp;
                if (r_mp == r_nm1) begin
                    n_state = S_NEXT;
                end else begin
                    n_r     = r_r + 1'b1;
                    n_state = S_SQ;
                end
            end
            S_NEXT: begin
                if (r_idx == LAST_IDX) begin
                    n_res   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_WIT;
                end
            end
            S_FIN: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_oprime = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_ret    <= n_ret;
        r_n      <= n_n;
        r_nm1    <= n_nm1;
        r_d      <= n_d;
        r_s      <= n_s;
        r_r      <= n_r;
        r_e      <= n_e;
        r_acc    <= n_acc;
        r_b      <= n_b;
        r_mx     <= n_mx;
        r_my     <= n_my;
        r_mp     <= n_mp;
        r_cnt    <= n_cnt;
        r_sub    <= n_sub;
        r_idx    <= n_idx;
        r_res    <= n_res;
        r_oprime <= n_oprime;
    end

    a_mul_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_mp < r_n && r_mx < r_n))
        else $error("modular accumulator left the residue range");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SPLIT || r_state == S_FIN))
        else $error("accepted request did not start a test");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && (!r_ovalid || i_out_ready)) |=> (r_ovalid && r_oprime == $past(r_res)))
        else $error("finished result was not presented");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WIT) |-> (r_idx <= LAST_IDX))
        else $error("witness index past the last base");

endmodule
